FILE: rtl/core/rounded_rect_span_gen_macros.svh
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: assertion macros
// Shared concurrent assertion forms; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_SPAN_GEN_MACROS_SVH
`define ROUNDED_RECT_SPAN_GEN_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rounded_rect_span_gen: assertion failed");

// next-cycle implication
`define RRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rounded_rect_span_gen: assertion failed");

`else

`define RRS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/rrs_pkg.sv
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: package
// Widths, register indexes and the records passed between front, queue and back.
// ----------------------------------------------------------------------------
package rrs_pkg;

   localparam int MAX_DIM    = 1024;
   localparam int CLIP_W     = 11;
   localparam int DIM_W      = 10;
   localparam int POS_W      = 12;
   localparam int COORD_W    = 13;
   localparam int COLOR_W    = 16;
   localparam int RAD_W      = 9;
   localparam int Q_W        = 2 * RAD_W;
   localparam int SQ_STEPS   = RAD_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;

   localparam logic [CLIP_W-1:0] CLIP_RESET = CLIP_W'(240);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_WIDTH  = 1'b0,
      CSR_CLIP_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CLIP_W-1:0] width;
      logic [CLIP_W-1:0] height;
   } clip_cfg_type;

   // one classified row, as queued between front and back
   typedef struct packed {
      logic                      kill;
      logic                      band;
      logic [RAD_W-1:0]          radius;
      logic [Q_W-1:0]            r_sq;
      logic [Q_W-1:0]            dy_sq;
      logic signed [COORD_W-1:0] y;
      logic signed [POS_W-1:0]   left;
      logic [DIM_W-1:0]          width;
      logic [COLOR_W-1:0]        color;
   } span_job_type;

   // row context carried along the root pipeline
   typedef struct packed {
      logic                      kill;
      logic                      band;
      logic [RAD_W-1:0]          radius;
      logic signed [COORD_W-1:0] y;
      logic signed [POS_W-1:0]   left;
      logic [DIM_W-1:0]          width;
      logic [COLOR_W-1:0]        color;
   } span_ctx_type;

   typedef struct packed {
      span_ctx_type   ctx;
      logic [Q_W-1:0] rem;
      logic [Q_W-1:0] res;
   } sqrt_step_type;

endpackage

FILE: rtl/core/rrs_front.sv
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: front end
// Accepts row requests, clamps the radius, picks the corner band and squares
// the radius and band offset; three registered stages feeding the queue.
// ----------------------------------------------------------------------------
module rrs_front import rrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rect_left[11:0], rect_top[23:12], rect_width[33:24], rect_height[43:34],
   // corner_radius[53:44], row_index[63:54], fill_color[79:64]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  q_full,
   output logic                  q_push,
   output span_job_type          q_data
);

   typedef struct packed {
      logic                      kill;
      logic [RAD_W-1:0]          radius;
      logic [DIM_W-1:0]          row;
      logic [DIM_W-1:0]          height;
      logic signed [COORD_W-1:0] y;
      logic signed [POS_W-1:0]   left;
      logic [DIM_W-1:0]          width;
      logic [COLOR_W-1:0]        color;
   } front_s1_type;

   typedef struct packed {
      logic                      kill;
      logic                      band;
      logic [RAD_W-1:0]          radius;
      logic [RAD_W-1:0]          dy;
      logic signed [COORD_W-1:0] y;
      logic signed [POS_W-1:0]   left;
      logic [DIM_W-1:0]          width;
      logic [COLOR_W-1:0]        color;
   } front_s2_type;

   logic         advance;
   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   front_s1_type s1_ff, s1_in;
   front_s2_type s2_ff, s2_in;
   span_job_type s3_ff, s3_in;

   // hold the whole front while the last stage cannot transfer into the queue
   assign advance    = !s3_valid_ff || !q_full;
   assign req_tready = advance;
   assign q_push     = s3_valid_ff && !q_full;
   assign q_data     = s3_ff;

   // stage 1: unpack, flag empty rows, clamp radius, target row
   always_comb begin
      logic [POS_W-1:0] top;
      logic [DIM_W-1:0] rw, rh, cr, side;
      logic [RAD_W-1:0] half;
      top  = req_tdata[23:12];
      rw   = req_tdata[33:24];
      rh   = req_tdata[43:34];
      cr   = req_tdata[53:44];
      side = (rw < rh) ? rw : rh;
      half = side[DIM_W-1:1];
      s1_in.row    = req_tdata[63:54];
      s1_in.kill   = (rw == '0) || (rh == '0) || (s1_in.row >= rh);
      s1_in.radius = (cr > {1'b0, half}) ? half : cr[RAD_W-1:0];
      s1_in.height = rh;
      s1_in.y      = {top[POS_W-1], top} + {3'b000, s1_in.row};
      s1_in.left   = req_tdata[11:0];
      s1_in.width  = rw;
      s1_in.color  = req_tdata[79:64];
   end

   // stage 2: pick top or bottom corner band and its distance from the center row
   always_comb begin
      logic             in_top, in_bot;
      logic [DIM_W-1:0] bot_start;
      logic [DIM_W:0]   dy_bot_w;
      in_top    = s1_ff.row < {1'b0, s1_ff.radius};
      bot_start = s1_ff.height - {1'b0, s1_ff.radius};
      in_bot    = s1_ff.row >= bot_start;
      dy_bot_w  = {1'b0, s1_ff.row} + {2'b00, s1_ff.radius} + (DIM_W+1)'(1)
                  - {1'b0, s1_ff.height};
      s2_in.kill   = s1_ff.kill;
      s2_in.band   = in_top || in_bot;
      s2_in.radius = s1_ff.radius;
      if (in_top) begin
         s2_in.dy = s1_ff.radius - s1_ff.row[RAD_W-1:0];
      end else if (in_bot) begin
         s2_in.dy = dy_bot_w[RAD_W-1:0];
      end else begin
         s2_in.dy = '0;
      end
      s2_in.y     = s1_ff.y;
      s2_in.left  = s1_ff.left;
      s2_in.width = s1_ff.width;
      s2_in.color = s1_ff.color;
   end

   // stage 3: square radius and offset
   always_comb begin
      s3_in.kill   = s2_ff.kill;
      s3_in.band   = s2_ff.band;
      s3_in.radius = s2_ff.radius;
      s3_in.r_sq   = Q_W'(s2_ff.radius) * Q_W'(s2_ff.radius);
      s3_in.dy_sq  = Q_W'(s2_ff.dy) * Q_W'(s2_ff.dy);
      s3_in.y      = s2_ff.y;
      s3_in.left   = s2_ff.left;
      s3_in.width  = s2_ff.width;
      s3_in.color  = s2_ff.color;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

endmodule

FILE: rtl/core/rrs_fifo.sv
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: job queue
// Four-entry queue of classified rows between front and back end.
// ----------------------------------------------------------------------------
`include "rounded_rect_span_gen_macros.svh"

module rrs_fifo import rrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  span_job_type push_data,
   output logic         full,
   input  logic         pop,
   output span_job_type pop_data,
   output logic         empty
);

   span_job_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RRS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `RRS_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `RRS_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !empty)

endmodule

FILE: rtl/core/rrs_back.sv
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: back end
// Pipelined integer square root (one result bit per stage), corner inset,
// clipping and the output register.
// ----------------------------------------------------------------------------
`include "rounded_rect_span_gen_macros.svh"

module rrs_back import rrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  clip_cfg_type          clip,
   input  span_job_type          q_data,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // span_row[9:0], span_x_first[19:10], span_x_end[30:20],
   // span_color[46:31], zero[47]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // span_visible[0]
   output logic                  rsp_tuser
);

   typedef struct packed {
      logic                      kill;
      logic                      len_pos;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] x1;
      logic [COLOR_W-1:0]        color;
   } span_geom_type;

   logic                advance;
   logic                sq_valid_ff [SQ_STEPS+1];
   sqrt_step_type       sq_ff       [SQ_STEPS+1];
   sqrt_step_type       sq_in       [SQ_STEPS+1];
   logic                geom_valid_ff;
   span_geom_type       geom_ff, geom_in;
   logic                out_valid_ff;
   logic                out_vis_ff, out_vis_in;
   logic [DIM_W-1:0]    out_row_ff, out_row_in;
   logic [DIM_W-1:0]    out_first_ff, out_first_in;
   logic [CLIP_W-1:0]   out_end_ff, out_end_in;
   logic [COLOR_W-1:0]  out_color_ff, out_color_in;

   // whole back end moves when the output register is free or draining
   assign advance    = !out_valid_ff || rsp_tready;
   assign q_pop      = advance && !q_empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tdata  = {1'b0, out_color_ff, out_end_ff, out_first_ff, out_row_ff};

   // root stages: load remainder, then one result bit per stage
   always_comb begin
      logic [Q_W-1:0] step_bit;
      logic [Q_W:0]   trial;
      sq_in[0].ctx.kill   = q_data.kill;
      sq_in[0].ctx.band   = q_data.band;
      sq_in[0].ctx.radius = q_data.radius;
      sq_in[0].ctx.y      = q_data.y;
      sq_in[0].ctx.left   = q_data.left;
      sq_in[0].ctx.width  = q_data.width;
      sq_in[0].ctx.color  = q_data.color;
      sq_in[0].rem        = q_data.r_sq - q_data.dy_sq;
      sq_in[0].res        = '0;
      for (int k = 1; k <= SQ_STEPS; k++) begin
         step_bit         = Q_W'(1) << (Q_W - 2 * k);
         trial            = {1'b0, sq_ff[k-1].res} + {1'b0, step_bit};
         sq_in[k].ctx     = sq_ff[k-1].ctx;
         if ({1'b0, sq_ff[k-1].rem} >= trial) begin
            sq_in[k].rem = sq_ff[k-1].rem - trial[Q_W-1:0];
            sq_in[k].res = (sq_ff[k-1].res >> 1) + step_bit;
         end else begin
            sq_in[k].rem = sq_ff[k-1].rem;
            sq_in[k].res = sq_ff[k-1].res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_STEPS; k++) begin
            sq_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         sq_valid_ff[0] <= !q_empty;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            sq_valid_ff[k] <= sq_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= SQ_STEPS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // inset both sides by radius minus root inside a corner band
   always_comb begin
      span_ctx_type      ctx;
      logic [RAD_W-1:0]  inset;
      logic [DIM_W:0]    len;
      ctx             = sq_ff[SQ_STEPS].ctx;
      inset           = ctx.band ? ctx.radius - sq_ff[SQ_STEPS].res[RAD_W-1:0] : '0;
      len             = {1'b0, ctx.width} - {1'b0, inset, 1'b0};
      geom_in.kill    = ctx.kill;
      geom_in.len_pos = len != '0;
      geom_in.y       = ctx.y;
      geom_in.x0      = {ctx.left[POS_W-1], ctx.left} + {4'b0000, inset};
      geom_in.x1      = {ctx.left[POS_W-1], ctx.left} + {3'b000, ctx.width}
                        - {4'b0000, inset};
      geom_in.color   = ctx.color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_valid_ff <= 1'b0;
      end else if (advance) begin
         geom_valid_ff <= sq_valid_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geom_ff <= geom_in;
      end
   end

   // clip to the target area; hidden spans come out as zeros
   always_comb begin
      logic signed [COORD_W-1:0] cw, ch, x0c, x1c;
      logic                      y_ok;
      cw         = {2'b00, clip.width};
      ch         = {2'b00, clip.height};
      y_ok       = !geom_ff.y[COORD_W-1] && (geom_ff.y < ch);
      x0c        = geom_ff.x0[COORD_W-1] ? '0 : geom_ff.x0;
      x1c        = (geom_ff.x1 > cw) ? cw : geom_ff.x1;
      out_vis_in = !geom_ff.kill && geom_ff.len_pos && y_ok && (x1c > x0c);
      if (out_vis_in) begin
         out_row_in   = geom_ff.y[DIM_W-1:0];
         out_first_in = x0c[DIM_W-1:0];
         out_end_in   = x1c[CLIP_W-1:0];
         out_color_in = geom_ff.color;
      end else begin
         out_row_in   = '0;
         out_first_in = '0;
         out_end_in   = '0;
         out_color_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= geom_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_vis_ff   <= out_vis_in;
         out_row_ff   <= out_row_in;
         out_first_ff <= out_first_in;
         out_end_ff   <= out_end_in;
         out_color_ff <= out_color_in;
      end
   end

   `RRS_ASSERT_IMPL(a_span_order, clock, reset, out_valid_ff && out_vis_ff, {1'b0, out_first_ff} < out_end_ff)
   `RRS_ASSERT_IMPL(a_hidden_zero, clock, reset, out_valid_ff && !out_vis_ff, rsp_tdata == '0)

endmodule

FILE: rtl/core/rounded_rect_span_gen.sv
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: top level
// Turns one row request of a filled rounded rectangle into one clipped span.
// ----------------------------------------------------------------------------
// Usage: each transfer on req_* names one row of a rectangle (corner, size,
// corner radius, row index, color); exactly one transfer on rsp_* follows per
// request, in order, carrying the clipped span and its visible flag in
// rsp_tuser. A hidden span carries all-zero rsp_tdata.
// Clip width and height are written on csr_* (index 0 width, 1 height) while
// the block is idle; values above 1024 are held as 1024.
// Throughput: one row per cycle when nothing stalls, set by the nine-stage
// square root pipeline that produces one root bit per stage.
// Reset clears all valid state and sets both clip registers to 240.
// When rsp_tready is low the back end holds; the four-entry queue and the three
// front stages keep taking requests until the queue fills, then req_tready drops.
// ----------------------------------------------------------------------------
`include "rounded_rect_span_gen_macros.svh"

module rounded_rect_span_gen import rrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rect_left[11:0], rect_top[23:12], rect_width[33:24], rect_height[43:34],
   // corner_radius[53:44], row_index[63:54], fill_color[79:64]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // span_row[9:0], span_x_first[19:10], span_x_end[30:20],
   // span_color[46:31], zero[47]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // span_visible[0]
   output logic                  rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CLIP_W-1:0]     csr_wr_data
);

   clip_cfg_type      clip_ff, clip_in;
   logic [CLIP_W-1:0] wr_clamped;
   logic              q_push, q_pop, q_full, q_empty;
   span_job_type      q_push_data, q_pop_data;

   // clamp and write clip registers
   always_comb begin
      wr_clamped = (csr_wr_data > CLIP_W'(MAX_DIM)) ? CLIP_W'(MAX_DIM) : csr_wr_data;
      clip_in    = clip_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_CLIP_WIDTH:  clip_in.width  = wr_clamped;
            CSR_CLIP_HEIGHT: clip_in.height = wr_clamped;
            default:         clip_in        = clip_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff.width  <= CLIP_RESET;
         clip_ff.height <= CLIP_RESET;
      end else begin
         clip_ff <= clip_in;
      end
   end

   rrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   rrs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   rrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clip       (clip_ff),
      .q_data     (q_pop_data),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `RRS_ASSERT_IMPL(a_stall_only_when_full, clock, reset, !req_tready, q_full)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rounded rectangle span generator: testbench
// Drives row requests over the req_ stream and checks every span on the rsp_
// stream against an in-bench span calculator. The clip size is set over the
// csr_ port between phases. Both stream sides are throttled at random, and the
// output is also held off long enough for the block to back up.
// ----------------------------------------------------------------------------
module tb;
   import rrs_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 32;
   localparam int MAX_REPORTS   = 10;

   // one row request, first field in the lowest bits
   typedef struct packed {
      logic [15:0]        fill_color;
      logic [9:0]         row_index;
      logic [9:0]         corner_radius;
      logic [9:0]         rect_height;
      logic [9:0]         rect_width;
      logic signed [11:0] rect_top;
      logic signed [11:0] rect_left;
   } row_request_type;

   // rsp_tdata layout, first field in the lowest bits
   typedef struct packed {
      logic        pad;
      logic [15:0] span_color;
      logic [10:0] span_x_end;
      logic [9:0]  span_x_first;
      logic [9:0]  span_row;
   } span_word_type;

   typedef struct packed {
      logic        span_visible;
      logic [9:0]  span_row;
      logic [9:0]  span_x_first;
      logic [10:0] span_x_end;
      logic [15:0] span_color;
   } span_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CLIP_W-1:0]     csr_wr_data;

   // clip size as last written, and the spans still owed by the block
   logic [CLIP_W-1:0] clip_width_cfg;
   logic [CLIP_W-1:0] clip_height_cfg;
   span_result_type   pending_spans[$];

   int   error_count   = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_off_req  = 1'b0;

   rounded_rect_span_gen u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // floor of the square root, one result bit at a time from the top
   function automatic int int_sqrt(input int v);
      int root;
      root = 0;
      for (int b = 9; b >= 0; b--) begin
         if ((root + (1 << b)) * (root + (1 << b)) <= v) root += 1 << b;
      end
      return root;
   endfunction

   // span of one row under the current clip size
   function automatic span_result_type predict_span(input row_request_type rq);
      span_result_type sp;
      int left, top, w, h, r, row, cw, ch, inset, dy, y, len, x0, x1;
      sp    = '0;
      left  = rq.rect_left;
      top   = rq.rect_top;
      w     = rq.rect_width;
      h     = rq.rect_height;
      r     = rq.corner_radius;
      row   = rq.row_index;
      cw    = (clip_width_cfg > MAX_DIM) ? MAX_DIM : int'(clip_width_cfg);
      ch    = (clip_height_cfg > MAX_DIM) ? MAX_DIM : int'(clip_height_cfg);
      if (w == 0 || h == 0 || row >= h) return sp;
      if (r > (w < h ? w : h) / 2) r = (w < h ? w : h) / 2;
      // inset from the top corner band, then the bottom one, keep the larger
      inset = 0;
      if (row < r) inset = r - int_sqrt(r * r - (r - row) * (r - row));
      dy = row - (h - 1 - r);
      if (dy > 0 && r - int_sqrt(r * r - dy * dy) > inset) begin
         inset = r - int_sqrt(r * r - dy * dy);
      end
      y   = top + row;
      len = w - 2 * inset;
      if (y < 0 || y >= ch || len <= 0) return sp;
      x0 = left + inset;
      x1 = x0 + len;
      if (x0 < 0) x0 = 0;
      if (x1 > cw) x1 = cw;
      if (x1 <= x0) return sp;
      sp.span_visible = 1'b1;
      sp.span_row     = y[9:0];
      sp.span_x_first = x0[9:0];
      sp.span_x_end   = x1[10:0];
      sp.span_color   = rq.fill_color;
      return sp;
   endfunction

   function automatic row_request_type mk_row(input int left, input int top, input int w,
                                              input int h, input int r, input int row,
                                              input int color);
      row_request_type rq;
      rq.rect_left     = 12'(left);
      rq.rect_top      = 12'(top);
      rq.rect_width    = 10'(w);
      rq.rect_height   = 10'(h);
      rq.corner_radius = 10'(r);
      rq.row_index     = 10'(row);
      rq.fill_color    = 16'(color);
      return rq;
   endfunction

   // mostly small sizes, a few up to the full range
   function automatic int pick_dim();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return $urandom_range(1, 40);
      if (sel < 85) return $urandom_range(1, 300);
      return $urandom_range(1, 1023);
   endfunction

   // well-formed rows near the clip area, with some raw noise mixed in
   function automatic row_request_type random_row();
      row_request_type rq;
      logic [95:0]     raw;
      int w, h, r, row, cw, ch, y, k, sel;
      if ($urandom_range(99) < 25) begin
         raw = {$urandom, $urandom, $urandom};
         rq  = raw[REQ_DATA_W-1:0];
         return rq;
      end
      w   = pick_dim();
      h   = pick_dim();
      cw  = (clip_width_cfg > MAX_DIM) ? MAX_DIM : int'(clip_width_cfg);
      ch  = (clip_height_cfg > MAX_DIM) ? MAX_DIM : int'(clip_height_cfg);
      sel = $urandom_range(99);
      if (sel < 50) r = $urandom_range(0, (w < h ? w : h) / 2 + 1);
      else if (sel < 80) r = $urandom_range(0, 1023);
      else r = (w < h ? w : h) / 2;
      // favor rows in the corner bands
      if ($urandom_range(1)) begin
         k   = $urandom_range(0, (h - 1 < 12) ? h - 1 : 12);
         row = $urandom_range(1) ? k : h - 1 - k;
      end else begin
         row = $urandom_range(0, h - 1);
      end
      y  = int'($urandom_range(0, ch + 3)) - 2;
      rq = mk_row(int'($urandom_range(0, cw + w)) - w, y - row, w, h, r, row, $urandom);
      return rq;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%t ERROR %s", $realtime, msg);
   endtask

   task automatic check_span(input logic visible, input span_word_type got);
      span_result_type exp;
      if (pending_spans.size() == 0) begin
         report_error($sformatf("span with no pending request: vis=%0b word=%h",
                                visible, got));
         return;
      end
      exp = pending_spans.pop_front();
      if (visible !== exp.span_visible || got.span_row !== exp.span_row ||
          got.span_x_first !== exp.span_x_first || got.span_x_end !== exp.span_x_end ||
          got.span_color !== exp.span_color || got.pad !== 1'b0) begin
         report_error($sformatf({"span mismatch: exp vis=%0b row=%0d x=[%0d,%0d) col=%h",
                                 " | got vis=%0b row=%0d x=[%0d,%0d) col=%h pad=%0b"},
                                exp.span_visible, exp.span_row, exp.span_x_first,
                                exp.span_x_end, exp.span_color, visible, got.span_row,
                                got.span_x_first, got.span_x_end, got.span_color, got.pad));
      end
   endtask

   // offer one row after a random gap; valid stays up after the transfer
   task automatic send_row(input row_request_type rq);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq;
      do @(posedge clock); while (!req_tready);
      pending_spans.push_back(predict_span(rq));
   endtask

   // drop valid and wait for every owed span
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clip(input int w, input int h);
      csr_wr_en   <= 1'b1;
      csr_addr    <= CSR_CLIP_WIDTH;
      csr_wr_data <= CLIP_W'(w);
      @(posedge clock);
      csr_addr    <= CSR_CLIP_HEIGHT;
      csr_wr_data <= CLIP_W'(h);
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      clip_width_cfg  = CLIP_W'(w);
      clip_height_cfg = CLIP_W'(h);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // field extremes and each hidden-span case, under the reset clip size
   task automatic test_directed_rows();
      send_row(mk_row(10, 10, 0, 20, 3, 0, 'hFFFF));        // zero width
      send_row(mk_row(10, 10, 20, 0, 3, 0, 'h1234));        // zero height
      send_row(mk_row(10, 10, 20, 5, 2, 5, 'h1111));        // row at height
      send_row(mk_row(10, 10, 20, 5, 2, 1023, 'h2222));     // row far beyond
      send_row(mk_row(10, -20, 20, 30, 4, 5, 'h3333));      // above clip
      send_row(mk_row(10, 235, 20, 30, 4, 5, 'h4444));      // below clip
      send_row(mk_row(10, -2048, 20, 30, 4, 5, 'h5555));
      send_row(mk_row(2047, 2047, 1023, 1023, 1023, 0, 'hFFFF));
      send_row(mk_row(-2048, -800, 1023, 1023, 1023, 1022, 0));
      send_row(mk_row(-300, -800, 1023, 1023, 1023, 1022, 'hABCD));
      send_row(mk_row(5, 5, 2, 2, 1, 0, 'h0F0F));           // inset eats span
      send_row(mk_row(5, 5, 3, 3, 1, 0, 'hF0F0));
      send_row(mk_row(0, 0, 240, 240, 0, 0, 'h8001));       // full clip row
      send_row(mk_row(-50, 100, 100, 10, 0, 3, 'h0001));    // cut on the left
      send_row(mk_row(200, 100, 100, 10, 0, 3, 'h0002));    // cut on the right
      send_row(mk_row(-100, 100, 100, 10, 0, 3, 'h0003));   // all left of clip
      send_row(mk_row(240, 100, 10, 10, 0, 3, 'h0004));     // all right of clip
      send_row(mk_row(20, 20, 64, 64, 16, 0, 'h0005));      // top corner band
      send_row(mk_row(20, 20, 64, 64, 16, 5, 'h0006));
      send_row(mk_row(20, 20, 64, 64, 16, 63, 'h0007));     // bottom corner band
      send_row(mk_row(20, 20, 64, 64, 16, 32, 'h0008));
      send_row(mk_row(20, 20, 40, 10, 1023, 9, 'h0009));    // radius clamped
      send_row(mk_row(2047, 0, 1023, 5, 0, 0, 'h000A));
      send_row(mk_row(0, 239, 10, 5, 0, 0, 'h000B));        // last clip row
   endtask

   // clip sizes at and beyond the extremes; -1 picks a random value
   task automatic test_clip_settings();
      int widths[7]  = '{1024, 2047, 1, 0, 640, 1023, -1};
      int heights[7] = '{1024, 2047, 1, 0, 480, 2, -1};
      for (int i = 0; i < 7; i++) begin
         wait_idle();
         write_clip(widths[i] < 0 ? $urandom_range(0, 2047) : widths[i],
                    heights[i] < 0 ? $urandom_range(0, 2047) : heights[i]);
         repeat (60) send_row(random_row());
      end
   endtask

   // hold the output off while rows keep coming, then pause until drained
   task automatic test_output_stall();
      int saved_pct;
      wait_idle();
      write_clip(240, 240);
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      hold_off_req  = 1'b1;
      repeat (60) send_row(random_row());
      send_idle_pct = saved_pct;
      wait_idle();
   endtask

   task automatic test_random_rows(input int count);
      repeat (count) send_row(random_row());
   endtask

   task automatic test_random_clips();
      for (int i = 0; i < 5; i++) begin
         wait_idle();
         if ($urandom_range(3) == 0) write_clip($urandom_range(0, 2047), $urandom_range(0, 2047));
         else write_clip($urandom_range(1, 1024), $urandom_range(1, 1024));
         repeat (90) send_row(random_row());
      end
   endtask

   // result side: check each transfer, then pick the next ready
   initial begin : span_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_span(rsp_tuser, rsp_tdata);
         if (hold_off_req) begin
            stall_left   = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // end the run when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      reset           <= 1'b1;
      req_tvalid      <= 1'b0;
      req_tdata       <= '0;
      csr_wr_en       <= 1'b0;
      csr_addr        <= CSR_CLIP_WIDTH;
      csr_wr_data     <= '0;
      clip_width_cfg  = CLIP_RESET;
      clip_height_cfg = CLIP_RESET;
      set_idle(37, 62);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_rows();
      test_clip_settings();
      set_idle(62, 37);
      test_output_stall();
      test_random_rows(320);
      set_idle(0, 0);
      test_random_clips();

      // collect the last spans and watch for strays
      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rrs_pkg.sv
rtl/core/rrs_front.sv
rtl/core/rrs_fifo.sv
rtl/core/rrs_back.sv
rtl/core/rounded_rect_span_gen.sv
tb/sv/tb.sv
